// File: hw/rtl/dtr_pkg.sv
// Shared opcodes, timing constants and speed decode for the divider/timer block.
`default_nettype none
package dtr_pkg;

  localparam int OVERFLOW_DELAY_CLOCKS = 4;
  localparam int RELOAD_WINDOW_CLOCKS  = 4;
  localparam int DELAY_W               = 3;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_WR_DIV    = 3'd1;
  localparam logic [2:0] OP_WR_CTRL   = 3'd2;
  localparam logic [2:0] OP_WR_MODULO = 3'd3;
  localparam logic [2:0] OP_WR_TIMER  = 3'd4;

  localparam logic [DELAY_W-1:0] DELAY_LOAD  = DELAY_W'(OVERFLOW_DELAY_CLOCKS);
  localparam logic [DELAY_W-1:0] WINDOW_LOAD = DELAY_W'(RELOAD_WINDOW_CLOCKS);

  // control bit 2 enables the timer, bits 1..0 pick the counter tap
  typedef struct packed {
    logic       enable;
    logic [1:0] speed;
  } ctrl_t;

  function automatic logic [3:0] tap_index(input logic [1:0] speed);
    logic [3:0] idx;
    case (speed)
      2'd0:    idx = 4'd9;
      2'd1:    idx = 4'd3;
      2'd2:    idx = 4'd5;
      default: idx = 4'd7;
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/divider_timer_with_reload_delay_top.sv
// Divider and timer with delayed overflow reload: state update and result register.
//
// Usage:
//   Request channel (req_valid / req_stall): opcode and write_data. Opcode 0 is
//   one machine clock tick; 1 clears the divider; 2, 3, 4 write control, modulo
//   and timer. Opcodes 5..7 change nothing.
//   Response channel (rsp_valid / rsp_stall): one word per request carrying the
//   timer count, divider byte and the interrupt flag after that request.
//   The response word is registered and is shown in the cycle after its request is accepted.
//   One request is taken per cycle while req_stall is low; the whole state update is a single
//   combinational pass from the state registers into the response register.
//   req_stall rises only while a response word is held and rsp_stall is high;
//   a held word does not change, and the next request waits in the sender.
//   Synchronous reset clears the counter, timer, modulo, control and the
//   overflow/reload sequencing, and empties the response register.
`default_nettype none
module divider_timer_with_reload_delay_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] write_data,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [7:0]      timer_value,
  output logic [7:0]      divider_value,
  output logic            timer_irq
);
  import dtr_pkg::*;

  logic [15:0]        free_counter;
  logic [7:0]         timer_count;
  logic [7:0]         modulo_value;
  ctrl_t              control_bits;
  logic               overflow_pending;
  logic [DELAY_W-1:0] overflow_delay;
  logic [DELAY_W-1:0] reload_window;

  logic [15:0]        free_counter_next;
  logic [7:0]         timer_count_next;
  logic [7:0]         modulo_value_next;
  ctrl_t              control_bits_next;
  logic               overflow_pending_next;
  logic [DELAY_W-1:0] overflow_delay_next;
  logic [DELAY_W-1:0] reload_window_next;
  logic               irq_next;

  logic               bump;
  logic               old_on;
  ctrl_t              new_ctrl;
  logic [7:0]         bumped;
  logic               accept;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign old_on    = free_counter[tap_index(control_bits.speed)];
  assign new_ctrl  = ctrl_t'(write_data[2:0]);

  always_comb begin
    free_counter_next     = free_counter;
    timer_count_next      = timer_count;
    modulo_value_next     = modulo_value;
    control_bits_next     = control_bits;
    overflow_pending_next = overflow_pending;
    overflow_delay_next   = overflow_delay;
    reload_window_next    = reload_window;
    irq_next              = 1'b0;
    bump                  = 1'b0;

    case (opcode)
      OP_TICK: begin
        if (reload_window != '0) begin
          reload_window_next = reload_window - DELAY_W'(1);
        end
        if (overflow_pending) begin
          if (overflow_delay <= DELAY_W'(1)) begin
            overflow_delay_next   = '0;
            overflow_pending_next = 1'b0;
            if (timer_count != 8'd0) begin
              // timer rewritten during the delay: reload cancelled
              reload_window_next = '0;
            end else begin
              irq_next           = 1'b1;
              timer_count_next   = modulo_value;
              reload_window_next = WINDOW_LOAD;
            end
          end else begin
            overflow_delay_next = overflow_delay - DELAY_W'(1);
          end
        end
        free_counter_next = free_counter + 16'd1;
        // falling edge of the selected tap
        bump = control_bits.enable && old_on &&
               !free_counter_next[tap_index(control_bits.speed)];
      end
      OP_WR_DIV: begin
        free_counter_next = '0;
        bump = control_bits.enable && old_on;
      end
      OP_WR_CTRL: begin
        if (control_bits.enable) begin
          if (!new_ctrl.enable) begin
            bump = old_on;
          end else begin
            bump = old_on && !free_counter[tap_index(new_ctrl.speed)];
          end
        end
        control_bits_next = new_ctrl;
      end
      OP_WR_MODULO: begin
        if (reload_window != '0) begin
          timer_count_next   = write_data;
          reload_window_next = '0;
        end
        modulo_value_next = write_data;
      end
      OP_WR_TIMER: begin
        if (reload_window == '0) begin
          timer_count_next = write_data;
        end
      end
      default: ;
    endcase

    bumped = timer_count_next + 8'd1;
    if (bump) begin
      timer_count_next = bumped;
      if (bumped == 8'd0) begin
        overflow_pending_next = 1'b1;
        overflow_delay_next   = DELAY_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_counter     <= '0;
      timer_count      <= '0;
      modulo_value     <= '0;
      control_bits     <= '0;
      overflow_pending <= 1'b0;
      overflow_delay   <= '0;
      reload_window    <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (accept) begin
        free_counter     <= free_counter_next;
        timer_count      <= timer_count_next;
        modulo_value     <= modulo_value_next;
        control_bits     <= control_bits_next;
        overflow_pending <= overflow_pending_next;
        overflow_delay   <= overflow_delay_next;
        reload_window    <= reload_window_next;
        rsp_valid        <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response word, loaded only with an accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      timer_value   <= timer_count_next;
      divider_value <= free_counter_next[15:8];
      timer_irq     <= irq_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dtr_checker.sv
// Port-level checker for the divider/timer block and its bind.
`default_nettype none
module dtr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_stall,
  input wire logic [2:0] opcode,
  input wire logic       rsp_valid,
  input wire logic       rsp_stall,
  input wire logic [7:0] timer_value,
  input wire logic [7:0] divider_value,
  input wire logic       timer_irq
);
  import dtr_pkg::*;

  // every accepted request shows up as a response word on the next cycle
  a_accept_to_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> rsp_valid)
    else $error("accepted request produced no response");

  // only a tick can complete the delayed reload
  a_irq_tick_only: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && opcode != OP_TICK) |=> !timer_irq)
    else $error("interrupt on a non-tick request");

  // divider write clears the counter
  a_div_clear: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && opcode == OP_WR_DIV) |=> divider_value == 8'd0)
    else $error("divider not cleared by divider write");

  // held response word stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(timer_value) && $stable(divider_value) &&
       $stable(timer_irq)))
    else $error("stalled response changed");

endmodule

bind divider_timer_with_reload_delay_top dtr_checker u_dtr_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_stall     (req_stall),
  .opcode        (opcode),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .timer_value   (timer_value),
  .divider_value (divider_value),
  .timer_irq     (timer_irq)
);
`default_nettype wire

// File: tb/dtr_word_checker.sv
`timescale 1ns / 1ps
// Divider/timer checker: predicts each response word and compares it with the block.
module dtr_word_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic       req_stall,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] write_data,
  input  wire logic       rsp_valid,
  input  wire logic       rsp_stall,
  input  wire logic [7:0] timer_value,
  input  wire logic [7:0] divider_value,
  input  wire logic       timer_irq,
  output int              fail_count,
  output int              pending_words,
  output int              words_checked,
  output int              reloads_seen,
  output int              reloads_cancelled
);
  import dtr_pkg::*;

  typedef struct {
    logic [7:0] timer;
    logic [7:0] divider;
    logic       irq;
  } timer_word_t;

  timer_word_t expected_words[$];
  timer_word_t got_expect;
  timer_word_t next_expect;

  // predicted block state
  logic [15:0]        model_count;
  logic [7:0]         model_timer;
  logic [7:0]         model_modulo;
  ctrl_t              model_ctrl;
  logic               ovf_pending;
  logic [DELAY_W-1:0] ovf_delay;
  logic [DELAY_W-1:0] reload_window;

  int mismatches    = 0;
  int checked_count = 0;
  int irq_count     = 0;
  int cancel_count  = 0;

  function automatic logic [15:0] tap_mask(input logic [1:0] speed);
    case (speed)
      2'd0:    return 16'h0200;
      2'd1:    return 16'h0008;
      2'd2:    return 16'h0020;
      default: return 16'h0080;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 20)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want_v, got_v);
  endtask

  task automatic clear_model();
    model_count   = '0;
    model_timer   = '0;
    model_modulo  = '0;
    model_ctrl    = '0;
    ovf_pending   = 1'b0;
    ovf_delay     = '0;
    reload_window = '0;
  endtask

  task automatic bump_timer();
    model_timer = model_timer + 8'd1;
    if (model_timer == 8'd0) begin
      ovf_pending = 1'b1;
      ovf_delay   = DELAY_LOAD;
    end
  endtask

  task automatic predict_word(input logic [2:0] op, input logic [7:0] data,
                              output timer_word_t w);
    logic        irq;
    logic [15:0] prev;
    logic [15:0] mask;
    logic        old_on;
    logic        glitch;
    logic [2:0]  nv;
    irq = 1'b0;
    case (op)
      OP_TICK: begin
        if (reload_window != 0) reload_window = reload_window - DELAY_W'(1);
        if (ovf_pending) begin
          if (ovf_delay <= 1) begin
            ovf_delay   = '0;
            ovf_pending = 1'b0;
            if (model_timer != 0) begin
              // timer rewritten during the delay: reload dropped
              reload_window = '0;
              cancel_count++;
            end else begin
              irq           = 1'b1;
              model_timer   = model_modulo;
              reload_window = WINDOW_LOAD;
            end
          end else begin
            ovf_delay = ovf_delay - DELAY_W'(1);
          end
        end
        prev        = model_count;
        model_count = model_count + 16'd1;
        mask        = tap_mask(model_ctrl.speed);
        if (model_ctrl.enable && (prev & mask) != 0 && (model_count & mask) == 0)
          bump_timer();
      end
      OP_WR_DIV: begin
        old_on      = (model_count & tap_mask(model_ctrl.speed)) != 0;
        model_count = '0;
        if (model_ctrl.enable && old_on) bump_timer();
      end
      OP_WR_CTRL: begin
        nv     = data[2:0];
        glitch = 1'b0;
        if (model_ctrl.enable) begin
          old_on = (model_count & tap_mask(model_ctrl.speed)) != 0;
          if (!nv[2]) glitch = old_on;
          else glitch = old_on && (model_count & tap_mask(nv[1:0])) == 0;
        end
        if (glitch) bump_timer();
        model_ctrl = ctrl_t'(nv);
      end
      OP_WR_MODULO: begin
        // a modulo write inside the reload window lands in the timer too
        if (reload_window != 0) begin
          model_timer   = data;
          reload_window = '0;
        end
        model_modulo = data;
      end
      OP_WR_TIMER: begin
        if (reload_window == 0) model_timer = data;
      end
      default: ;
    endcase
    w.timer   = model_timer;
    w.divider = model_count[15:8];
    w.irq     = irq;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      expected_words.delete();
    end else begin
      // response first: the response word is registered, so it never belongs to this edge's request
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected response word", 0, timer_value);
        end else begin
          got_expect = expected_words.pop_front();
          if (timer_value !== got_expect.timer)
            report_mismatch("timer_value", got_expect.timer, timer_value);
          if (divider_value !== got_expect.divider)
            report_mismatch("divider_value", got_expect.divider, divider_value);
          if (timer_irq !== got_expect.irq)
            report_mismatch("timer_irq", got_expect.irq, timer_irq);
          checked_count++;
          if (got_expect.irq) irq_count++;
        end
      end
      if (req_valid && !req_stall) begin
        predict_word(opcode, write_data, next_expect);
        expected_words.push_back(next_expect);
      end
    end
    fail_count        <= mismatches;
    pending_words     <= expected_words.size();
    words_checked     <= checked_count;
    reloads_seen      <= irq_count;
    reloads_cancelled <= cancel_count;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Divider/timer testbench top: clock, reset, request/response stimulus and verdict.
module tb;
  import dtr_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int ITEM_TARGET     = 650;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int STUCK_LIMIT     = 1000;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       req_valid  = 1'b0;
  logic       req_stall;
  logic [2:0] opcode     = OP_TICK;
  logic [7:0] write_data = 8'h00;
  logic       rsp_valid;
  logic       rsp_stall  = 1'b0;
  logic [7:0] timer_value;
  logic [7:0] divider_value;
  logic       timer_irq;

  logic calm         = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;

  int fail_count;
  int pending_words;
  int words_checked;
  int reloads_seen;
  int reloads_cancelled;
  int issued = 0;
  int stuck_cycles;

  divider_timer_with_reload_delay_top dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .write_data    (write_data),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .timer_value   (timer_value),
    .divider_value (divider_value),
    .timer_irq     (timer_irq)
  );

  dtr_word_checker u_word_checker (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .opcode            (opcode),
    .write_data        (write_data),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .timer_value       (timer_value),
    .divider_value     (divider_value),
    .timer_irq         (timer_irq),
    .fail_count        (fail_count),
    .pending_words     (pending_words),
    .words_checked     (words_checked),
    .reloads_seen      (reloads_seen),
    .reloads_cancelled (reloads_cancelled)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic send_word(input logic [2:0] op, input logic [7:0] data);
    while (!calm && $urandom_range(99) < 16) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    opcode     <= op;
    write_data <= data;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    issued++;
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    send_word(3'($urandom_range(7)), 8'($urandom_range(255)));
  endtask

  // preload the timer near wrap, then mostly ticks with writes mixed in,
  // so overflow delay, reload window and their write races get exercised
  task automatic run_overflow_scenario();
    int n;
    int pick;
    logic [1:0] speed;
    speed = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd1;
    send_word(OP_WR_MODULO, 8'($urandom_range(255)));
    send_word(OP_WR_CTRL, {5'($urandom_range(31)), 1'b1, speed});
    if ($urandom_range(3) == 0) send_word(OP_WR_DIV, 8'($urandom_range(255)));
    send_word(OP_WR_TIMER, 8'($urandom_range(255, 252)));
    n = $urandom_range(40, 20);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 70)
        send_word(OP_TICK, 8'($urandom_range(255)));
      else if (pick < 78)
        send_word(OP_WR_TIMER, $urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
      else if (pick < 86)
        send_word(OP_WR_MODULO, 8'($urandom_range(255)));
      else if (pick < 92)
        send_word(OP_WR_CTRL, {5'($urandom_range(31)), ($urandom_range(4) != 0),
                               2'($urandom_range(3))});
      else if (pick < 97)
        send_word(OP_WR_DIV, 8'($urandom_range(255)));
      else
        send_word(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), 8'($urandom_range(255)));
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        rsp_stall <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("no word moved for %0d cycles", STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit drained;
    bit hold_armed;
    drained    = 1'b0;
    hold_armed = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: spare opcodes, field extremes, control and divider glitches,
    // glitch-driven overflow through the delay, then writes inside the window
    send_word(OP_TICK, 8'h00);
    send_word(OP_SPARE_FIRST, 8'hFF);
    send_word(OP_SPARE_LAST, 8'h00);
    send_word(OP_WR_MODULO, 8'hFF);
    send_word(OP_WR_TIMER, 8'h00);
    send_word(OP_WR_CTRL, 8'hFF);
    send_word(OP_WR_CTRL, 8'h00);
    send_word(OP_WR_DIV, 8'hFF);
    send_word(OP_WR_TIMER, 8'hFF);
    send_word(OP_WR_CTRL, 8'h05);
    repeat (8) send_word(OP_TICK, 8'hFF);
    // tap bit 3 is high now; moving to speed 0 bumps the timer through wrap
    send_word(OP_WR_CTRL, 8'h04);
    repeat (4) send_word(OP_TICK, 8'h00);
    send_word(OP_WR_TIMER, 8'h12);
    send_word(OP_WR_MODULO, 8'h00);

    while (issued < ITEM_TARGET) begin
      if (!hold_armed && issued >= 200) begin
        hold_off_req <= 1'b1;
        hold_armed = 1'b1;
      end
      if (!drained && issued >= 500) begin
        drain_responses();
        drained = 1'b1;
      end
      calm <= (issued >= 350 && issued < 470);
      if ($urandom_range(99) < 75) run_overflow_scenario();
      else repeat ($urandom_range(8, 1)) send_noise();
    end

    drain_responses();
    repeat (4) @(posedge clk);
    $display("sent %0d words, checked %0d responses", issued, words_checked);
    $display("saw %0d reload interrupts and %0d cancelled reloads",
             reloads_seen, reloads_cancelled);
    if (fail_count == 0 && pending_words == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
